[hw/rtl/cbaf_pkg.sv]
package cbaf_pkg;

    localparam int MAX_BOX_DEF     = 63;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HW_W            = 5;
    localparam int CNT_W           = 7;
    localparam int COUNT_SAT       = 127;
    localparam int FRAC_W          = 8;
    localparam int MEAN_W          = 24;
    localparam logic [HW_W-1:0] HW_RESET = 5'd1;

    typedef struct packed {
        logic take;
        logic rd_fl;
        logic upd;
        logic sub;
        logic div_start;
        logic load;
        logic run_last;
        logic row_last;
        logic dec_d;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic emit_main;
        logic row_end;
        logic d_zero;
        logic d_one;
        logic need_sub;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/centered_box_average_filter.sv]
// Each item taken updates the window sum; where it owes a result, the sum is divided by
// the bit-serial divider (a quotient of SAMPLE_BITS + clog2(MAX_BOX+1) + 8 bits, 30 at
// the defaults) and the mean is put in the output register. A row end also owes flush
// results, each after the samples that leave the window are dropped from the sum. A new
// item is taken only once the last one is through; output stalls hold it back.
// Synchronous active-low reset clears the row state and sets half width to 1.
module centered_box_average_filter import cbaf_pkg::*; #(
    parameter int MAX_BOX     = MAX_BOX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [HW_W-1:0]                      i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
    input  logic                                 s_axis_tlast,  // row_end
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [MEAN_W-1:0]                    m_axis_tdata,  // mean
    output logic                                 m_axis_tlast,  // row_last
    output logic                                 m_axis_tuser   // run_last
);
    t_cmd cmd;
    t_sts sts;

    cbaf_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cbaf_dp #(
        .MAX_BOX     (MAX_BOX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_row_end   (s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_mean      (m_axis_tdata),
        .o_row_last  (m_axis_tlast),
        .o_run_last  (m_axis_tuser)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    a_row_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("row end without run end");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> sts.out_free)
        else $error("output overwritten");

endmodule

[hw/rtl/cbaf_div.sv]
module cbaf_div import cbaf_pkg::*; #(
    parameter int SUM_W = 22
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [SUM_W-1:0]         i_sum,
    input  logic        [CNT_W-1:0]         i_divisor,
    output logic                            o_done,
    output logic signed [SUM_W+FRAC_W-1:0]  o_quot
);
    localparam int QW = SUM_W + FRAC_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic             r_done;
    logic [QW-1:0]    dvd;
    logic [CNT_W:0]   rem_sh;
    logic             q_bit;

    assign dvd    = {i_sum, {FRAC_W{1'b0}}};
    assign rem_sh = {r_rem, r_q[QW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[SUM_W-1];
            r_q   <= i_sum[SUM_W-1] ? (~dvd + 1'b1) : dvd;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= q_bit ? CNT_W'(rem_sh - {1'b0, r_dvs}) : CNT_W'(rem_sh);
            r_q   <= {r_q[QW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? signed'(~r_q + 1'b1) : signed'(r_q);

endmodule

[hw/rtl/cbaf_dp.sv]
module cbaf_dp import cbaf_pkg::*; #(
    parameter int MAX_BOX     = MAX_BOX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [HW_W-1:0]               i_cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_row_end,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [MEAN_W-1:0]             o_mean,
    output logic                          o_row_last,
    output logic                          o_run_last
);
    localparam int DEPTH = MAX_BOX + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int HMAX  = (MAX_BOX - 1) / 2;
    localparam int SUM_W = SAMPLE_BITS + AW;
    localparam int QW    = SUM_W + FRAC_W;

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_end;
    logic signed [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]              r_rc;
    logic [CNT_W-1:0]              r_cur;
    logic [HW_W-1:0]               r_d;
    logic [AW-1:0]                 r_wp;
    logic [HW_W-1:0]               r_hw;
    logic                          r_ovalid;
    logic [MEAN_W-1:0]             r_mean;
    logic                          r_row_last;
    logic                          r_run_last;

    logic [HW_W-1:0]               h;
    logic [CNT_W-1:0]              h_c;
    logic [CNT_W-1:0]              w;
    logic [CNT_W-1:0]              k;
    logic [CNT_W-1:0]              hd;
    logic [CNT_W-1:0]              lim;
    logic [CNT_W-1:0]              span;
    logic [AW-1:0]                 span_a;
    logic [AW-1:0]                 raddr;
    logic signed [SUM_W-1:0]       smp_x;
    logic signed [SUM_W-1:0]       rd_x;
    logic                          div_done;
    logic signed [QW-1:0]          quot;
    logic signed [QW+MEAN_W-1:0]   quot_x;

    assign h      = (int'(r_hw) > HMAX) ? HW_W'(HMAX) : r_hw;
    assign h_c    = CNT_W'(h);
    assign w      = CNT_W'({h, 1'b1});
    assign k      = (r_rc < CNT_W'(COUNT_SAT)) ? r_rc + 1'b1 : r_rc;
    assign hd     = h_c + CNT_W'(r_d);
    assign lim    = (r_rc < hd) ? r_rc : hd;
    assign span   = i_cmd.take ? w : r_cur;
    assign span_a = AW'(span);
    assign raddr  = (r_wp >= span_a) ? r_wp - span_a
                  : AW'(({1'b0, r_wp} + (AW+1)'(DEPTH)) - {1'b0, span_a});
    assign smp_x  = SUM_W'(r_smp);
    assign rd_x   = SUM_W'(r_rdata);
    assign quot_x = (QW+MEAN_W)'(quot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take || i_cmd.rd_fl) begin
            r_rdata <= r_mem[raddr];
        end
        if (i_cmd.upd) begin
            r_mem[r_wp] <= r_smp;
        end
        if (i_cmd.take) begin
            r_smp <= i_sample;
            r_end <= i_row_end;
        end
        if (i_cmd.load) begin
            r_mean     <= quot_x[MEAN_W-1:0];
            r_row_last <= i_cmd.row_last;
            r_run_last <= i_cmd.run_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw     <= HW_RESET;
            r_sum    <= '0;
            r_rc     <= '0;
            r_cur    <= '0;
            r_d      <= '0;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.clr || i_cfg_we) begin
                r_sum <= '0;
                r_rc  <= '0;
                r_cur <= '0;
                r_d   <= '0;
                r_wp  <= '0;
            end else begin
                if (i_cmd.upd) begin
                    r_sum <= r_sum + smp_x - ((r_rc >= w) ? rd_x : '0);
                    r_wp  <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    r_rc  <= k;
                    r_cur <= (k < w) ? k : w;
                    r_d   <= (k < h_c) ? HW_W'(k) : h;
                end
                if (i_cmd.sub) begin
                    r_sum <= r_sum - rd_x;
                    r_cur <= r_cur - 1'b1;
                end
                if (i_cmd.dec_d) begin
                    r_d <= r_d - 1'b1;
                end
            end
            if (i_cfg_we) begin
                r_hw <= i_cfg_wdata;
            end
        end
    end

    cbaf_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_sum     (r_sum),
        .i_divisor (r_cur),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    always_comb begin
        o_sts.emit_main = (r_rc >= h_c + 1'b1);
        o_sts.row_end   = r_end;
        o_sts.d_zero    = (r_d == '0);
        o_sts.d_one     = (r_d == HW_W'(1));
        o_sts.need_sub  = (r_cur > lim);
        o_sts.div_done  = div_done;
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_mean      = r_mean;
    assign o_row_last  = r_row_last;
    assign o_run_last  = r_run_last;

endmodule

[hw/rtl/cbaf_ctl.sv]
module cbaf_ctl import cbaf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_FL   = 3'd3;
    localparam logic [2:0] S_FSUB = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_fl;
    logic       n_fl;
    logic       more;

    assign o_in_ready = (r_state == S_IDLE);
    assign more = r_fl ? !i_sts.d_one : (i_sts.row_end && !i_sts.d_zero);

    always_comb begin
        n_state = r_state;
        n_fl    = r_fl;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_fl = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                if (i_sts.emit_main) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_sts.row_end) begin
                    n_fl    = 1'b1;
                    n_state = S_FL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FL: begin
                if (i_sts.need_sub) begin
                    o_cmd.rd_fl = 1'b1;
                    n_state     = S_FSUB;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_FSUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_FL;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.run_last = !more;
                    o_cmd.row_last = i_sts.row_end && !more;
                    o_cmd.dec_d    = r_fl;
                    o_cmd.clr      = i_sts.row_end && !more;
                    n_fl           = 1'b1;
                    n_state        = more ? S_FL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fl    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fl    <= n_fl;
        end
    end

endmodule
